@@ rtl/mafm_pkg.sv @@
// mafm_pkg: shared constants, types and codes for the multichannel average fault monitor
// no dependencies; imported by every other file of the block except mafm_ram
package mafm_pkg;

    localparam int CHANNELS     = 4;
    localparam int CH_BITS      = 2;
    localparam int SAMPLE_BITS  = 20;
    localparam int LIMIT_BITS   = 20;
    localparam int MAX_WINDOW   = 8;
    localparam int WIN_BITS     = 4;

    localparam int POS_BITS     = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int FILL_BITS    = $clog2(MAX_WINDOW + 1);
    localparam int TOTAL_BITS   = SAMPLE_BITS + POS_BITS;
    localparam int CMP_BITS     = ((SAMPLE_BITS > LIMIT_BITS) ? SAMPLE_BITS : LIMIT_BITS) + 2;

    // long division, DIV_STEP quotient bits per cycle
    localparam int DIV_STEP     = 8;
    localparam int DIV_CYCLES   = (TOTAL_BITS + DIV_STEP - 1) / DIV_STEP;
    localparam int DIV_BITS     = DIV_CYCLES * DIV_STEP;
    localparam int DIV_CNT_BITS = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;

    localparam int RAM_ADDR_BITS = CH_BITS + POS_BITS;
    localparam int RAM_DEPTH     = 1 << RAM_ADDR_BITS;

    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 3 * LIMIT_BITS;

    localparam logic [CFG_INDEX_BITS-1:0] REG_WINDOW      = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_LIMITS_BASE = 3'd1;

    localparam logic [WIN_BITS-1:0] WINDOW_RESET = 4'd8;

    typedef enum logic [1:0] {
        FAULT_NONE      = 2'd0,
        FAULT_OVER_MAX  = 2'd1,
        FAULT_UNDER_MIN = 2'd2,
        FAULT_HIGH_RATE = 2'd3
    } fault_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_DIV,
        ST_FINISH
    } state_t;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic update;
        logic div_step;
        logic finish;
    } cmd_t;

endpackage

@@ rtl/mafm_if.sv @@
// mafm_in_if / mafm_out_if: valid-ready channels for samples and results
// depends on mafm_pkg
interface mafm_in_if;
    import mafm_pkg::*;

    logic                          valid;
    logic                          ready;
    logic [CH_BITS-1:0]            channel_index;
    logic signed [SAMPLE_BITS-1:0] sample_value;

    modport source (output valid, output channel_index, output sample_value, input ready);
    modport sink   (input valid, input channel_index, input sample_value, output ready);
endinterface

interface mafm_out_if;
    import mafm_pkg::*;

    logic                          valid;
    logic                          ready;
    logic [CH_BITS-1:0]            result_channel;
    logic signed [SAMPLE_BITS-1:0] averaged_value;
    logic [1:0]                    fault_code;

    modport source (output valid, output result_channel, output averaged_value,
                    output fault_code, input ready);
    modport sink   (input valid, input result_channel, input averaged_value,
                    input fault_code, output ready);
endinterface

@@ rtl/mafm_ram.sv @@
// mafm_ram: generic single write port, single read port ram with registered read
// no dependencies
module mafm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/mafm_ctrl.sv @@
// mafm_ctrl: sequencing state machine and result valid flag
// depends on mafm_pkg
module mafm_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    output logic           out_valid,
    input  logic           out_ready,
    output mafm_pkg::cmd_t cmd
);
    import mafm_pkg::*;

    state_t                  state_reg, state_next;
    logic [DIV_CNT_BITS-1:0] div_cnt_reg, div_cnt_next;
    logic                    out_valid_reg, out_valid_next;
    logic                    out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            div_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            div_cnt_reg   <= div_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next   = state_reg;
        div_cnt_next = div_cnt_reg;
        cmd          = '0;
        in_ready     = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                cmd.update   = 1'b1;
                div_cnt_next = '0;
                state_next   = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (div_cnt_reg == DIV_CNT_BITS'(DIV_CYCLES - 1))
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    div_cnt_next = div_cnt_reg + 1'b1;
                end
            end
            ST_FINISH:
            begin
                // hold until the result register can take the new transaction
                if (out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cmd.finish)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

@@ rtl/mafm_datapath.sv @@
// mafm_datapath: config registers, per-channel history, sample ring, divider and classifier
// depends on mafm_pkg and mafm_ram
module mafm_datapath (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  mafm_pkg::cmd_t                          cmd,
    input  logic [mafm_pkg::CH_BITS-1:0]            channel_index,
    input  logic signed [mafm_pkg::SAMPLE_BITS-1:0] sample_value,
    input  logic                                    cfg_we,
    input  logic [mafm_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
    input  logic [mafm_pkg::CFG_DATA_BITS-1:0]      cfg_data,
    output logic [mafm_pkg::CH_BITS-1:0]            result_channel,
    output logic signed [mafm_pkg::SAMPLE_BITS-1:0] averaged_value,
    output mafm_pkg::fault_t                        fault_code
);
    import mafm_pkg::*;

    // configuration
    logic [WIN_BITS-1:0]      win_reg, win_next;
    logic [CFG_DATA_BITS-1:0] lim_reg [CHANNELS];
    logic [CFG_DATA_BITS-1:0] lim_next [CHANNELS];

    // per-channel history
    logic [POS_BITS-1:0]          wp_reg [CHANNELS];
    logic [POS_BITS-1:0]          wp_next [CHANNELS];
    logic [FILL_BITS-1:0]         fill_reg [CHANNELS];
    logic [FILL_BITS-1:0]         fill_next [CHANNELS];
    logic signed [TOTAL_BITS-1:0] total_reg [CHANNELS];
    logic signed [TOTAL_BITS-1:0] total_next [CHANNELS];
    logic signed [SAMPLE_BITS-1:0] prev_reg [CHANNELS];
    logic signed [SAMPLE_BITS-1:0] prev_next [CHANNELS];
    logic [CHANNELS-1:0]          seen_reg, seen_next;

    // transaction in flight
    logic [CH_BITS-1:0]            ch_reg;
    logic signed [SAMPLE_BITS-1:0] sample_reg;
    logic                          neg_reg;
    logic [FILL_BITS-1:0]          divisor_reg;
    logic [FILL_BITS-1:0]          rem_reg, rem_next;
    logic [DIV_BITS-1:0]           quo_reg, quo_next;

    // result register
    logic [CH_BITS-1:0]            res_ch_reg;
    logic signed [SAMPLE_BITS-1:0] avg_reg;
    fault_t                        fault_reg;

    logic [FILL_BITS-1:0]          win_eff;
    logic [SAMPLE_BITS-1:0]        ram_rdata;
    logic [POS_BITS-1:0]           cur_wp;
    logic [FILL_BITS-1:0]          cur_fill;
    logic                          full;
    logic signed [SAMPLE_BITS-1:0] old_sample;
    logic signed [TOTAL_BITS-1:0]  total_upd;
    logic [POS_BITS:0]             wp_inc;
    logic [POS_BITS-1:0]           wp_upd;
    logic [FILL_BITS-1:0]          fill_upd;
    logic [TOTAL_BITS-1:0]         total_mag;

    logic [FILL_BITS:0]            trial;
    logic [FILL_BITS-1:0]          rem_w;
    logic [DIV_BITS-1:0]           quo_w;

    logic [SAMPLE_BITS-1:0]        quo_low;
    logic signed [SAMPLE_BITS-1:0] mean;
    logic signed [CMP_BITS-1:0]    mean_x, prev_x, lo_x, hi_x, rate_x, diff_x, abs_x;
    logic [CFG_DATA_BITS-1:0]      cur_lim;
    fault_t                        code;

    always_comb
    begin
        if (win_reg == '0)
        begin
            win_eff = FILL_BITS'(1);
        end
        else if (32'(win_reg) > MAX_WINDOW)
        begin
            win_eff = FILL_BITS'(MAX_WINDOW);
        end
        else
        begin
            win_eff = FILL_BITS'(win_reg);
        end
    end

    mafm_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (RAM_DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (cmd.update),
        .waddr ({ch_reg, cur_wp}),
        .wdata (sample_reg),
        .re    (cmd.load),
        .raddr ({channel_index, wp_reg[channel_index]}),
        .rdata (ram_rdata)
    );

    // ring and running total update
    always_comb
    begin
        cur_wp     = wp_reg[ch_reg];
        cur_fill   = fill_reg[ch_reg];
        full       = (cur_fill >= win_eff);
        old_sample = full ? signed'(ram_rdata) : '0;
        total_upd  = total_reg[ch_reg] - TOTAL_BITS'(old_sample) + TOTAL_BITS'(sample_reg);
        wp_inc     = {1'b0, cur_wp} + 1'b1;
        wp_upd     = (wp_inc == (POS_BITS + 1)'(win_eff)) ? '0 : wp_inc[POS_BITS-1:0];
        fill_upd   = full ? cur_fill : cur_fill + 1'b1;
        total_mag  = total_upd[TOTAL_BITS-1] ? TOTAL_BITS'(-total_upd) : TOTAL_BITS'(total_upd);
    end

    // restoring division, DIV_STEP quotient bits per pass
    always_comb
    begin
        rem_w = rem_reg;
        quo_w = quo_reg;
        trial = '0;
        for (int i = 0; i < DIV_STEP; i++)
        begin
            trial = {rem_w, quo_w[DIV_BITS-1]};
            quo_w = {quo_w[DIV_BITS-2:0], 1'b0};
            if (trial >= {1'b0, divisor_reg})
            begin
                trial    = trial - {1'b0, divisor_reg};
                quo_w[0] = 1'b1;
            end
            rem_w = trial[FILL_BITS-1:0];
        end

        if (cmd.update)
        begin
            rem_next = '0;
            quo_next = DIV_BITS'(total_mag);
        end
        else if (cmd.div_step)
        begin
            rem_next = rem_w;
            quo_next = quo_w;
        end
        else
        begin
            rem_next = rem_reg;
            quo_next = quo_reg;
        end
    end

    // mean sign and fault classification
    always_comb
    begin
        quo_low = quo_reg[SAMPLE_BITS-1:0];
        mean    = neg_reg ? signed'(-quo_low) : signed'(quo_low);
        cur_lim = lim_reg[ch_reg];
        mean_x  = CMP_BITS'(mean);
        prev_x  = CMP_BITS'(prev_reg[ch_reg]);
        lo_x    = CMP_BITS'(signed'(cur_lim[LIMIT_BITS-1:0]));
        hi_x    = CMP_BITS'(signed'(cur_lim[2*LIMIT_BITS-1:LIMIT_BITS]));
        rate_x  = CMP_BITS'(signed'(cur_lim[3*LIMIT_BITS-1:2*LIMIT_BITS]));
        diff_x  = mean_x - prev_x;
        abs_x   = diff_x[CMP_BITS-1] ? -diff_x : diff_x;

        if (!seen_reg[ch_reg])
        begin
            code = FAULT_NONE;
        end
        else if (mean_x > hi_x)
        begin
            code = FAULT_OVER_MAX;
        end
        else if (mean_x < lo_x)
        begin
            code = FAULT_UNDER_MIN;
        end
        else if (abs_x > rate_x)
        begin
            code = FAULT_HIGH_RATE;
        end
        else
        begin
            code = FAULT_NONE;
        end
    end

    // next state of configuration and channel history
    always_comb
    begin
        win_next   = win_reg;
        lim_next   = lim_reg;
        wp_next    = wp_reg;
        fill_next  = fill_reg;
        total_next = total_reg;
        prev_next  = prev_reg;
        seen_next  = seen_reg;

        if (cmd.update)
        begin
            wp_next[ch_reg]    = wp_upd;
            fill_next[ch_reg]  = fill_upd;
            total_next[ch_reg] = total_upd;
        end
        if (cmd.finish)
        begin
            prev_next[ch_reg] = mean;
            seen_next[ch_reg] = 1'b1;
        end

        if (cfg_we)
        begin
            case (cfg_index)
                REG_WINDOW:
                begin
                    // new window length drops every channel history
                    win_next = cfg_data[WIN_BITS-1:0];
                    for (int c = 0; c < CHANNELS; c++)
                    begin
                        wp_next[c]    = '0;
                        fill_next[c]  = '0;
                        total_next[c] = '0;
                        prev_next[c]  = '0;
                    end
                    seen_next = '0;
                end
                default:
                begin
                    if (cfg_index >= REG_LIMITS_BASE &&
                        32'(cfg_index - REG_LIMITS_BASE) < CHANNELS)
                    begin
                        lim_next[CH_BITS'(cfg_index - REG_LIMITS_BASE)] = cfg_data;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg  <= WINDOW_RESET;
            seen_reg <= '0;
            for (int c = 0; c < CHANNELS; c++)
            begin
                lim_reg[c]   <= '0;
                wp_reg[c]    <= '0;
                fill_reg[c]  <= '0;
                total_reg[c] <= '0;
                prev_reg[c]  <= '0;
            end
        end
        else
        begin
            win_reg   <= win_next;
            lim_reg   <= lim_next;
            wp_reg    <= wp_next;
            fill_reg  <= fill_next;
            total_reg <= total_next;
            prev_reg  <= prev_next;
            seen_reg  <= seen_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            ch_reg     <= channel_index;
            sample_reg <= sample_value;
        end
        if (cmd.update)
        begin
            neg_reg     <= total_upd[TOTAL_BITS-1];
            divisor_reg <= fill_upd;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (cmd.finish)
        begin
            res_ch_reg <= ch_reg;
            avg_reg    <= mean;
            fault_reg  <= code;
        end
    end

    assign result_channel = res_ch_reg;
    assign averaged_value = avg_reg;
    assign fault_code     = fault_reg;

endmodule

@@ rtl/multichannel_average_fault_monitor.sv @@
// Multichannel moving-average fault monitor. Each sample transaction carries a channel
// (0..3) and a signed Q12.8 reading; the block keeps the last window_length readings of
// each channel in a ring memory and returns their mean (truncated toward zero) with a
// fault code: over max, else under min, else high rate of change against the channel's
// previous mean, else none; a channel's first sample after reset or after a window write
// never flags. Each sample passes through accept and ring read, ring write and running total
// update, three divider passes of 8 quotient bits each, then classification into the result
// register. Samples are taken one at a time: a new one is accepted only after the previous
// one has been classified. A finished result waits in the output register while the next
// sample is worked on. Writing register 0 (window_length) clears all channel histories at
// once; registers 1..4 hold the packed min, max and rate limits per channel. The user must
// write configuration only while no sample is in flight; the block does not enforce this.
module multichannel_average_fault_monitor (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [mafm_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [mafm_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    mafm_in_if.sink                             samples,
    mafm_out_if.source                          results
);
    import mafm_pkg::*;

    cmd_t   cmd;
    fault_t fault_code;

    mafm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (samples.valid),
        .in_ready  (samples.ready),
        .out_valid (results.valid),
        .out_ready (results.ready),
        .cmd       (cmd)
    );

    mafm_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .channel_index  (samples.channel_index),
        .sample_value   (samples.sample_value),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .result_channel (results.result_channel),
        .averaged_value (results.averaged_value),
        .fault_code     (fault_code)
    );

    assign results.fault_code = fault_code;

`ifndef SYNTHESIS
    // ring update always follows the accept of the same transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.update |-> $past(cmd.load))
        else $error("ring update without a preceding accept");

    // a held result is never overwritten
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> (!results.valid || results.ready))
        else $error("result register overwritten while still held");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> results.valid)
        else $error("finished transaction not presented");

    // one sample in flight at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        (samples.valid && samples.ready) |=> !samples.ready)
        else $error("second sample taken while one is in flight");
`endif

endmodule

@@ tb/multichannel_average_fault_monitor_test.sv @@
// self-checking bench for the multichannel average fault monitor: directed table, then random
// phases under random idling, checked against an in-bench windowed mean and fault classifier
// depends on mafm_pkg, mafm_in_if, mafm_out_if and multichannel_average_fault_monitor
module multichannel_average_fault_monitor_test;
    timeunit 1ns;
    timeprecision 1ps;

    import mafm_pkg::*;

    typedef struct packed {
        logic [CH_BITS-1:0]            chan;
        logic signed [SAMPLE_BITS-1:0] avg;
        fault_t                        code;
    } reading_t;

    typedef struct packed {
        logic                          is_write;
        logic [CFG_INDEX_BITS-1:0]     reg_index;
        logic [CFG_DATA_BITS-1:0]      reg_value;
        logic [CH_BITS-1:0]            chan;
        logic signed [SAMPLE_BITS-1:0] smp;
        logic                          known;
        logic signed [SAMPLE_BITS-1:0] avg;
        fault_t                        code;
    } step_t;

    localparam int SCRIPT_ROWS = 31;
    localparam logic [CFG_DATA_BITS-1:0] NO_DATA = '0;

    localparam step_t SCRIPT [SCRIPT_ROWS] = '{
        // reset limits are all zero, so any second sample off zero flags
        '{1'b0, REG_WINDOW, NO_DATA, 2'd0, 20'sh7FFFF, 1'b1, 20'sh7FFFF, FAULT_NONE},
        '{1'b0, REG_WINDOW, NO_DATA, 2'd0, 20'sh80000, 1'b1, 20'sd0, FAULT_HIGH_RATE},
        '{1'b0, REG_WINDOW, NO_DATA, 2'd1, 20'sh80000, 1'b1, 20'sh80000, FAULT_NONE},
        '{1'b0, REG_WINDOW, NO_DATA, 2'd1, 20'sh80000, 1'b1, 20'sh80000, FAULT_UNDER_MIN},
        '{1'b0, REG_WINDOW, NO_DATA, 2'd2, 20'sd1, 1'b1, 20'sd1, FAULT_NONE},
        '{1'b0, REG_WINDOW, NO_DATA, 2'd2, 20'sd1, 1'b1, 20'sd1, FAULT_OVER_MAX},
        '{1'b0, REG_WINDOW, NO_DATA, 2'd3, 20'sd0, 1'b1, 20'sd0, FAULT_NONE},
        '{1'b0, REG_WINDOW, NO_DATA, 2'd3, 20'sd0, 1'b1, 20'sd0, FAULT_NONE},
        '{1'b1, REG_LIMITS_BASE, {20'sd100, 20'sd1000, -20'sd1000},
          2'd0, 20'sd0, 1'b0, 20'sd0, FAULT_NONE},
        '{1'b1, REG_LIMITS_BASE + 3'd3, {-20'sd1, 20'sh7FFFF, 20'sh80000},
          2'd0, 20'sd0, 1'b0, 20'sd0, FAULT_NONE},
        // negative rate limit: even a zero change is too fast
        '{1'b0, REG_WINDOW, NO_DATA, 2'd3, 20'sd0, 1'b1, 20'sd0, FAULT_HIGH_RATE},
        // window of zero behaves as one
        '{1'b1, REG_WINDOW, 60'd0, 2'd0, 20'sd0, 1'b0, 20'sd0, FAULT_NONE},
        '{1'b0, REG_WINDOW, NO_DATA, 2'd0, 20'sd500, 1'b1, 20'sd500, FAULT_NONE},
        '{1'b0, REG_WINDOW, NO_DATA, 2'd0, 20'sd700, 1'b1, 20'sd700, FAULT_HIGH_RATE},
        '{1'b0, REG_WINDOW, NO_DATA, 2'd0, 20'sd750, 1'b1, 20'sd750, FAULT_NONE},
        // window above the maximum behaves as the maximum; ring wraps here
        '{1'b1, REG_WINDOW, 60'd15, 2'd0, 20'sd0, 1'b0, 20'sd0, FAULT_NONE},
        '{1'b0, REG_WINDOW, NO_DATA, 2'd0, 20'sd900, 1'b0, 20'sd0, FAULT_NONE},
        '{1'b0, REG_WINDOW, NO_DATA, 2'd0, -20'sd900, 1'b0, 20'sd0, FAULT_NONE},
        '{1'b0, REG_WINDOW, NO_DATA, 2'd0, 20'sd1000, 1'b0, 20'sd0, FAULT_NONE},
        '{1'b0, REG_WINDOW, NO_DATA, 2'd0, 20'sd1001, 1'b0, 20'sd0, FAULT_NONE},
        '{1'b0, REG_WINDOW, NO_DATA, 2'd0, -20'sd1001, 1'b0, 20'sd0, FAULT_NONE},
        '{1'b0, REG_WINDOW, NO_DATA, 2'd0, 20'sd20, 1'b0, 20'sd0, FAULT_NONE},
        '{1'b0, REG_WINDOW, NO_DATA, 2'd0, 20'sd40, 1'b0, 20'sd0, FAULT_NONE},
        '{1'b0, REG_WINDOW, NO_DATA, 2'd0, 20'sd60, 1'b0, 20'sd0, FAULT_NONE},
        '{1'b0, REG_WINDOW, NO_DATA, 2'd0, 20'sd80, 1'b0, 20'sd0, FAULT_NONE},
        '{1'b0, REG_WINDOW, NO_DATA, 2'd0, 20'sd100, 1'b0, 20'sd0, FAULT_NONE},
        // all-ones limits: min, max and rate are all minus one
        '{1'b1, REG_LIMITS_BASE + 3'd1, 60'hFFF_FFFF_FFFF_FFFF,
          2'd0, 20'sd0, 1'b0, 20'sd0, FAULT_NONE},
        '{1'b1, REG_WINDOW, 60'd1, 2'd0, 20'sd0, 1'b0, 20'sd0, FAULT_NONE},
        '{1'b0, REG_WINDOW, NO_DATA, 2'd1, -20'sd1, 1'b1, -20'sd1, FAULT_NONE},
        '{1'b0, REG_WINDOW, NO_DATA, 2'd1, 20'sd0, 1'b1, 20'sd0, FAULT_OVER_MAX},
        '{1'b0, REG_WINDOW, NO_DATA, 2'd1, -20'sd2, 1'b1, -20'sd2, FAULT_UNDER_MIN}
    };

    localparam int RANDOM_PHASES    = 12;
    localparam int PHASE_SAMPLES    = 100;

    logic clk;
    logic rst_n;
    logic                      cfg_we;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_data;

    mafm_in_if  sample_bus ();
    mafm_out_if result_bus ();

    multichannel_average_fault_monitor dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .samples   (sample_bus),
        .results   (result_bus)
    );

    // model state: configuration and per-channel history
    logic [WIN_BITS-1:0]           win_reg;
    logic [CFG_DATA_BITS-1:0]      chan_limits [CHANNELS];
    logic signed [SAMPLE_BITS-1:0] ring        [CHANNELS][MAX_WINDOW];
    int unsigned                   ring_pos    [CHANNELS];
    int unsigned                   fill        [CHANNELS];
    longint                        total       [CHANNELS];
    longint                        prev_mean   [CHANNELS];
    bit                            seen        [CHANNELS];

    reading_t pending_readings [$];

    // expectation typed into the table for the sample on offer
    bit                            row_known;
    logic signed [SAMPLE_BITS-1:0] row_avg;
    fault_t                        row_code;

    int src_idle_max;
    int snk_idle_max;
    int drain_hold;
    int mismatches;
    int samples_taken;
    int window_settings;
    int fault_tally [4];
    int chan_mid [CHANNELS];

    function automatic void forget_history();
        for (int c = 0; c < CHANNELS; c++)
        begin
            ring_pos[c]  = 0;
            fill[c]      = 0;
            total[c]     = 0;
            prev_mean[c] = 0;
            seen[c]      = 1'b0;
        end
    endfunction

    function automatic reading_t average_and_classify(input logic [CH_BITS-1:0] ch,
                                                      input logic signed [SAMPLE_BITS-1:0] smp);
        int unsigned w;
        int unsigned p;
        longint      lo;
        longint      hi;
        longint      rate;
        longint      mean;
        longint      delta;
        reading_t    r;
        w = (win_reg == 0) ? 1 : ((win_reg > MAX_WINDOW) ? MAX_WINDOW : win_reg);
        p = ring_pos[ch] % w;
        lo   = $signed(chan_limits[ch][LIMIT_BITS-1:0]);
        hi   = $signed(chan_limits[ch][2*LIMIT_BITS-1:LIMIT_BITS]);
        rate = $signed(chan_limits[ch][3*LIMIT_BITS-1:2*LIMIT_BITS]);
        if (fill[ch] >= w)
            total[ch] -= ring[ch][p];
        else
            fill[ch]++;
        ring[ch][p] = smp;
        total[ch] += smp;
        ring_pos[ch] = (p + 1) % w;
        mean = total[ch] / longint'(fill[ch]);
        r.code = FAULT_NONE;
        if (seen[ch])
        begin
            delta = mean - prev_mean[ch];
            if (delta < 0)
                delta = -delta;
            if (mean > hi)
                r.code = FAULT_OVER_MAX;
            else if (mean < lo)
                r.code = FAULT_UNDER_MIN;
            else if (delta > rate)
                r.code = FAULT_HIGH_RATE;
        end
        prev_mean[ch] = mean;
        seen[ch] = 1'b1;
        r.chan = ch;
        r.avg  = mean[SAMPLE_BITS-1:0];
        return r;
    endfunction

    task automatic flag_mismatch(input string msg);
        mismatches++;
        $display("%0t mismatch: %s", $time, msg);
    endtask

    task automatic write_register(input logic [CFG_INDEX_BITS-1:0] idx,
                                  input logic [CFG_DATA_BITS-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        if (idx == REG_WINDOW)
        begin
            win_reg = val[WIN_BITS-1:0];
            forget_history();
            window_settings++;
        end
        else if (idx >= REG_LIMITS_BASE && idx < REG_LIMITS_BASE + CHANNELS)
            chan_limits[CH_BITS'(idx - REG_LIMITS_BASE)] = val;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic offer_sample(input logic [CH_BITS-1:0] ch,
                                input logic signed [SAMPLE_BITS-1:0] val,
                                input bit known,
                                input logic signed [SAMPLE_BITS-1:0] avg,
                                input fault_t code);
        int gap;
        gap = $urandom_range(0, src_idle_max);
        repeat (gap)
        begin
            @(negedge clk);
            sample_bus.valid <= 1'b0;
        end
        @(negedge clk);
        row_known = known;
        row_avg   = avg;
        row_code  = code;
        sample_bus.valid         <= 1'b1;
        sample_bus.channel_index <= ch;
        sample_bus.sample_value  <= val;
        do
            @(posedge clk);
        while (!sample_bus.ready);
    endtask

    // drop valid and let every outstanding result drain, then keep idling as a margin
    task automatic wait_idle();
        @(negedge clk);
        sample_bus.valid <= 1'b0;
        while (pending_readings.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

    // result side: random stalls, plus an occasional long hold-off
    initial
    begin
        int gap;
        result_bus.ready = 1'b0;
        forever
        begin
            if (drain_hold > 0)
            begin
                @(negedge clk);
                result_bus.ready <= 1'b0;
                repeat (drain_hold - 1) @(negedge clk);
                drain_hold = 0;
            end
            else
            begin
                gap = $urandom_range(0, snk_idle_max);
                repeat (gap)
                begin
                    @(negedge clk);
                    result_bus.ready <= 1'b0;
                end
            end
            @(negedge clk);
            result_bus.ready <= 1'b1;
            do
                @(posedge clk);
            while (!(result_bus.valid && result_bus.ready));
        end
    end

    // predict on each accepted sample, check each accepted result
    always @(posedge clk)
    begin
        reading_t want;
        if (rst_n)
        begin
            if (sample_bus.valid && sample_bus.ready)
            begin
                want = average_and_classify(sample_bus.channel_index, sample_bus.sample_value);
                if (row_known)
                begin
                    want.avg  = row_avg;
                    want.code = row_code;
                end
                pending_readings.push_back(want);
                samples_taken++;
            end
            if (result_bus.valid && result_bus.ready)
            begin
                if (pending_readings.size() == 0)
                    flag_mismatch("result transaction with no sample outstanding");
                else
                begin
                    want = pending_readings.pop_front();
                    fault_tally[want.code]++;
                    if (result_bus.result_channel !== want.chan)
                        flag_mismatch($sformatf("channel %0d, expected %0d",
                                                result_bus.result_channel, want.chan));
                    if (result_bus.averaged_value !== want.avg)
                        flag_mismatch($sformatf("ch %0d average %0d, expected %0d", want.chan,
                                                result_bus.averaged_value, want.avg));
                    if (result_bus.fault_code !== want.code)
                        flag_mismatch($sformatf("ch %0d fault %0d, expected %0d (avg %0d)",
                                                want.chan, result_bus.fault_code, want.code,
                                                want.avg));
                end
            end
        end
    end

    initial
    begin
        logic [WIN_BITS-1:0]           win;
        logic [CH_BITS-1:0]            ch;
        logic signed [SAMPLE_BITS-1:0] val;
        int mode;
        int lo;
        int hi;
        int rate;
        int guard;

        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = REG_WINDOW;
        cfg_data  = '0;
        sample_bus.valid         = 1'b0;
        sample_bus.channel_index = '0;
        sample_bus.sample_value  = '0;
        row_known = 1'b0;
        row_avg   = '0;
        row_code  = FAULT_NONE;
        src_idle_max = 18;
        snk_idle_max = 18;
        drain_hold   = 0;
        mismatches   = 0;
        samples_taken   = 0;
        window_settings = 0;
        for (int k = 0; k < 4; k++)
            fault_tally[k] = 0;
        win_reg = WINDOW_RESET;
        for (int c = 0; c < CHANNELS; c++)
        begin
            chan_limits[c] = '0;
            chan_mid[c]    = 0;
        end
        forget_history();

        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        for (int i = 0; i < SCRIPT_ROWS; i++)
        begin
            if (SCRIPT[i].is_write)
            begin
                wait_idle();
                write_register(SCRIPT[i].reg_index, SCRIPT[i].reg_value);
            end
            else
                offer_sample(SCRIPT[i].chan, SCRIPT[i].smp, SCRIPT[i].known,
                             SCRIPT[i].avg, SCRIPT[i].code);
        end

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            wait_idle();
            for (int c = 0; c < CHANNELS; c++)
            begin
                mode = (p == 0) ? 5 : $urandom_range(0, 7);
                chan_mid[c] = int'($urandom_range(0, 4000)) - 2000;
                case (mode)
                    0: write_register(REG_LIMITS_BASE + 3'(c), '0);
                    1: write_register(REG_LIMITS_BASE + 3'(c), '1);
                    2: write_register(REG_LIMITS_BASE + 3'(c),
                                      CFG_DATA_BITS'({$urandom(), $urandom()}));
                    default:
                    begin
                        lo   = chan_mid[c] - int'($urandom_range(0, 2500));
                        hi   = chan_mid[c] + int'($urandom_range(0, 2500));
                        rate = $urandom_range(0, 1500);
                        write_register(REG_LIMITS_BASE + 3'(c),
                                       {20'(rate), 20'(hi), 20'(lo)});
                    end
                endcase
            end
            case (p)
                0:       win = 4'd1;
                1:       win = 4'd8;
                2:       win = 4'd0;
                3:       win = 4'd15;
                default: win = WIN_BITS'($urandom_range(0, 15));
            endcase
            write_register(REG_WINDOW, CFG_DATA_BITS'(win));

            src_idle_max = (p % 3 == 1) ? 0 : 18;
            snk_idle_max = (p % 4 == 2) ? 0 : 18;
            // long result stall while samples keep coming, so the input backs up
            if (p == 3 || p == 8)
                drain_hold = 250 + $urandom_range(0, 100);

            for (int n = 0; n < PHASE_SAMPLES; n++)
            begin
                ch = CH_BITS'($urandom_range(0, CHANNELS - 1));
                mode = $urandom_range(0, 9);
                if (mode == 0)
                    val = $urandom_range(0, 1) ? 20'sh7FFFF : 20'sh80000;
                else if (mode == 1)
                    val = SAMPLE_BITS'($urandom());
                else
                    val = SAMPLE_BITS'(chan_mid[ch] + int'($urandom_range(0, 6000)) - 3000);
                offer_sample(ch, val, 1'b0, '0, FAULT_NONE);
            end
        end

        @(negedge clk);
        sample_bus.valid <= 1'b0;
        guard = 0;
        while (pending_readings.size() != 0 && guard < 4000)
        begin
            @(negedge clk);
            guard++;
        end
        repeat (12) @(negedge clk);
        if (pending_readings.size() != 0)
            flag_mismatch($sformatf("%0d expected results never arrived",
                                    pending_readings.size()));

        $display("covered %0d samples over %0d window settings, all limit registers rewritten",
                 samples_taken, window_settings);
        $display("faults checked: %0d none, %0d over max, %0d under min, %0d high rate",
                 fault_tally[FAULT_NONE], fault_tally[FAULT_OVER_MAX],
                 fault_tally[FAULT_UNDER_MIN], fault_tally[FAULT_HIGH_RATE]);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

@@ files.f @@
rtl/mafm_pkg.sv
rtl/mafm_if.sv
rtl/mafm_ram.sv
rtl/mafm_ctrl.sv
rtl/mafm_datapath.sv
rtl/multichannel_average_fault_monitor.sv
tb/multichannel_average_fault_monitor_test.sv
